// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int ACTION_BITS   = 4;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 4'd0,
    ACT_SUB    = 4'd1,
    ACT_MUL    = 4'd2,
    ACT_DIV    = 4'd3,
    ACT_LT     = 4'd4,
    ACT_GT     = 4'd5,
    ACT_LE     = 4'd6,
    ACT_GE     = 4'd7,
    ACT_EQ     = 4'd8,
    ACT_NE     = 4'd9,
    ACT_MIN    = 4'd10,
    ACT_MAX    = 4'd11,
    ACT_INC    = 4'd12,
    ACT_DEC    = 4'd13,
    ACT_TO_INT = 4'd14
  } action_e;

endpackage

// ===== sv/fpa_in_if.sv =====
interface fpa_in_if #(
  parameter int WordBits = fpa_pkg::WORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [fpa_pkg::ACTION_BITS-1:0] action;
  logic signed [WordBits-1:0]    operand_a;
  logic signed [WordBits-1:0]    operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

// ===== sv/fpa_out_if.sv =====
interface fpa_out_if #(
  parameter int WordBits = fpa_pkg::WORD_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] result_value;
  logic                       compare_true;
  logic                       divide_by_zero;
  logic                       saturated;

  modport source (output valid, result_value, compare_true, divide_by_zero, saturated,
                  input ready);
  modport sink   (input valid, result_value, compare_true, divide_by_zero, saturated,
                  output ready);
endinterface

// ===== sv/fixed_point_alu_unit.sv =====
// Signed fixed-point ALU (default Q24.8). One beat in gives one beat out, in order.
// The pipeline takes a new beat every cycle while the output is not stalled. Each beat
// passes the input stage, the restoring divider that resolves one quotient bit per
// stage, the quotient rounding stage and the output register; all actions share that
// path. A stall at the output freezes the whole pipeline and nothing is lost or repeated.
// Multiply and divide round to nearest, ties away from zero, and saturate.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);
  import fpa_pkg::*;

  localparam int NS = WORD_BITS + FRAC_BITS;        // quotient bits / divider stages
  localparam int H  = (WORD_BITS + 1) / 2;          // multiplier half width
  localparam int PW = 2 * WORD_BITS;                // product width
  localparam int TW = PW + 1 - FRAC_BITS;           // rounded product width
  localparam int FW = (TW > NS + 1) ? TW : NS + 1;  // width seen by saturation
  localparam logic [WORD_BITS-1:0] MaxVal = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MinVal = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    action_e              act;
    logic                 neg;
    logic                 dz;
    logic [WORD_BITS-1:0] sres;
    logic                 scmp;
    logic [WORD_BITS-1:0] mres;
    logic                 msat;
  } meta_t;

  // Sign and saturate a magnitude; returns {sat, value}
  function automatic logic [WORD_BITS:0] finish(input logic [FW-1:0] q, input logic neg);
    logic [WORD_BITS:0] r;
    r = '0;
    if (q != '0) begin
      if (!neg) begin
        if (q > FW'(MaxVal)) r = {1'b1, MaxVal};
        else r = {1'b0, q[WORD_BITS-1:0]};
      end else begin
        if (q > FW'(MinVal)) r = {1'b1, MinVal};
        else r = {1'b0, WORD_BITS'(-q[WORD_BITS-1:0])};
      end
    end
    return r;
  endfunction

  logic en;
  logic ov_q;

  // Advance the whole pipeline whenever the output register can move
  assign en       = !ov_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- input stage: simple ops, magnitudes ----------------
  logic signed [WORD_BITS-1:0] a, b;
  action_e                     act_in;
  meta_t                       meta1_d, meta1_q;
  logic [WORD_BITS-1:0]        mag_a_d, mag_b_d, mag_a1_q, mag_b1_q;
  logic                        v1_q;

  assign a      = in_i.operand_a;
  assign b      = in_i.operand_b;
  assign act_in = action_e'(in_i.action);
  assign mag_a_d = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  assign mag_b_d = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

  always_comb begin
    meta1_d      = '0;
    meta1_d.act  = act_in;
    meta1_d.neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    meta1_d.dz   = (act_in == ACT_DIV) && (b == '0);
    case (act_in)
      ACT_ADD:    meta1_d.sres = WORD_BITS'(a + b);
      ACT_SUB:    meta1_d.sres = WORD_BITS'(a - b);
      ACT_LT:     meta1_d.scmp = a < b;
      ACT_GT:     meta1_d.scmp = b < a;
      ACT_LE:     meta1_d.scmp = !(b < a);
      ACT_GE:     meta1_d.scmp = !(a < b);
      ACT_EQ:     meta1_d.scmp = a == b;
      ACT_NE:     meta1_d.scmp = a != b;
      ACT_MIN:    meta1_d.sres = (a < b) ? a : b;
      ACT_MAX:    meta1_d.sres = (b < a) ? a : b;
      ACT_INC:    meta1_d.sres = WORD_BITS'(a + 1);
      ACT_DEC:    meta1_d.sres = WORD_BITS'(a - 1);
      ACT_TO_INT: meta1_d.sres = WORD_BITS'(a >>> FRAC_BITS);
      default:    meta1_d.sres = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta1_q  <= meta1_d;
      mag_a1_q <= mag_a_d;
      mag_b1_q <= mag_b_d;
    end
  end

  // ---------------- multiplier: partial products, sum, round ----------------
  logic [2*H-1:0] ma2, mb2;
  logic [2*H-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [PW-1:0]  prod_q;
  logic [TW-1:0]  t_q;
  logic [4*H-1:0] prod_d;
  logic [PW:0]    rnd_sum;

  assign ma2 = (2*H)'(mag_a1_q);
  assign mb2 = (2*H)'(mag_b1_q);
  assign prod_d = (4*H)'(pp00_q)
                + (((4*H)'(pp01_q) + (4*H)'(pp10_q)) << H)
                + ((4*H)'(pp11_q) << (2*H));
  assign rnd_sum = (PW+1)'(prod_q) + ((PW+1)'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp00_q <= ma2[H-1:0] * mb2[H-1:0];
      pp01_q <= ma2[H-1:0] * mb2[2*H-1:H];
      pp10_q <= ma2[2*H-1:H] * mb2[H-1:0];
      pp11_q <= ma2[2*H-1:H] * mb2[2*H-1:H];
      prod_q <= PW'(prod_d);
      t_q    <= TW'(rnd_sum >> FRAC_BITS);
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [WORD_BITS-1:0] dr_q [NS];
  logic [WORD_BITS-1:0] dd_q [NS];
  logic [NS-1:0]        dq_q [NS];
  logic [NS-1:0]        dn_q [NS];
  meta_t                dm_q [NS];
  logic [NS-1:0]        dv_q;

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [WORD_BITS-1:0] r_in, d_in, r_nx;
    logic [NS-1:0]        q_in, n_in;
    meta_t                m_in, m_out;
    logic                 v_in, ge;
    logic [WORD_BITS:0]   r_sh;
    logic [WORD_BITS+1:0] diff;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = NS'({mag_a1_q, {FRAC_BITS{1'b0}}});
      assign d_in = mag_b1_q;
      assign m_in = meta1_q;
      assign v_in = v1_q;
    end else begin : g_next
      assign r_in = dr_q[k-1];
      assign q_in = dq_q[k-1];
      assign n_in = dn_q[k-1];
      assign d_in = dd_q[k-1];
      assign m_in = dm_q[k-1];
      assign v_in = dv_q[k-1];
    end

    // Merge the finished product into the beat alongside it
    if (k == 3) begin : g_mul
      logic [WORD_BITS:0] mfin;
      assign mfin = finish(FW'(t_q), m_in.neg);
      always_comb begin
        m_out      = m_in;
        m_out.mres = mfin[WORD_BITS-1:0];
        m_out.msat = mfin[WORD_BITS];
      end
    end else begin : g_pass
      assign m_out = m_in;
    end

    // Shift in the next dividend bit, subtract when it fits
    assign r_sh = {r_in, n_in[NS-1]};
    assign diff = {1'b0, r_sh} - {2'b00, d_in};
    assign ge   = !diff[WORD_BITS+1];
    assign r_nx = ge ? diff[WORD_BITS-1:0] : r_sh[WORD_BITS-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[k] <= r_nx;
        dd_q[k] <= d_in;
        dq_q[k] <= {q_in[NS-2:0], ge};
        dn_q[k] <= {n_in[NS-2:0], 1'b0};
        dm_q[k] <= m_out;
      end
    end
  end

  // ---------------- quotient rounding ----------------
  logic          rnd_up;
  logic [NS:0]   rq_q;
  meta_t         rm_q;
  logic          rv_q;

  assign rnd_up = {dr_q[NS-1], 1'b0} >= {1'b0, dd_q[NS-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= dv_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq_q <= (NS+1)'(dq_q[NS-1]) + (NS+1)'(rnd_up);
      rm_q <= dm_q[NS-1];
    end
  end

  // ---------------- output register ----------------
  logic [WORD_BITS:0]   dfin;
  logic [WORD_BITS-1:0] res_d, res_q;
  logic                 cmp_d, dz_d, sat_d, cmp_q, dz_q, sat_q;

  assign dfin = finish(FW'(rq_q), rm_q.neg);

  always_comb begin
    res_d = rm_q.sres;
    cmp_d = rm_q.scmp;
    dz_d  = 1'b0;
    sat_d = 1'b0;
    case (rm_q.act)
      ACT_MUL: begin
        res_d = rm_q.mres;
        sat_d = rm_q.msat;
      end
      ACT_DIV: begin
        dz_d  = rm_q.dz;
        res_d = rm_q.dz ? '0 : dfin[WORD_BITS-1:0];
        sat_d = rm_q.dz ? 1'b0 : dfin[WORD_BITS];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= rv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      cmp_q <= cmp_d;
      dz_q  <= dz_d;
      sat_q <= sat_d;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.result_value   = res_q;
  assign out_o.compare_true   = cmp_q;
  assign out_o.divide_by_zero = dz_q;
  assign out_o.saturated      = sat_q;

  // ---------------- checks ----------------
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |-> out_o.result_value == '0 && !out_o.saturated)
    else $error("divide by zero beat carries a value or saturation");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.compare_true |-> out_o.result_value == '0 && !out_o.saturated)
    else $error("compare beat carries a value");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.result_value == MaxVal || out_o.result_value == MinVal)
    else $error("saturated beat is not at a range limit");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q) && $stable(rv_q))
    else $error("pipeline moved during a stall");

endmodule

// ===== sim/fpa_checker.sv =====
`timescale 1ns / 100ps

module fpa_checker #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic [fpa_pkg::ACTION_BITS-1:0] action_i,
  input  logic [WORD_BITS-1:0] operand_a_i,
  input  logic [WORD_BITS-1:0] operand_b_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  logic [WORD_BITS-1:0] result_value_i,
  input  logic compare_true_i,
  input  logic divide_by_zero_i,
  input  logic saturated_i,
  output int   fail_count_o,
  output int   pending_o
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 cmp;
    logic                 dz;
    logic                 sat;
  } alu_result_t;

  alu_result_t expected_results[$];

  localparam logic signed [WORD_BITS-1:0] MaxWord = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MinWord = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Clamp a signed exact value into the word range.
  function automatic alu_result_t clamp_word(logic signed [2*WORD_BITS+FRAC_BITS+2:0] q);
    alu_result_t r;
    r = '0;
    if (q > MaxWord) begin
      r.value = MaxWord;
      r.sat = 1'b1;
    end else if (q < MinWord) begin
      r.value = MinWord;
      r.sat = 1'b1;
    end else begin
      r.value = q[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic alu_result_t alu_predict(logic [ACTION_BITS-1:0] act,
                                              logic signed [WORD_BITS-1:0] a,
                                              logic signed [WORD_BITS-1:0] b);
    localparam int W = 2*WORD_BITS+FRAC_BITS+3;
    alu_result_t r;
    logic [W-1:0] ma, mb, mag, rem;
    logic signed [W-1:0] sq;
    logic neg;
    r = '0;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    ma = a[WORD_BITS-1] ? W'(-$signed({a[WORD_BITS-1], a})) : W'(a);
    mb = b[WORD_BITS-1] ? W'(-$signed({b[WORD_BITS-1], b})) : W'(b);
    case (act)
      ACT_ADD: r.value = a + b;
      ACT_SUB: r.value = a - b;
      ACT_MUL: begin
        // round half away from zero on the magnitude
        mag = (ma * mb + (W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        sq = neg ? -$signed(mag) : $signed(mag);
        r = clamp_word(sq);
      end
      ACT_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          mag = (ma << FRAC_BITS) / mb;
          rem = (ma << FRAC_BITS) % mb;
          if (rem >= mb - rem) mag = mag + 1;
          sq = neg ? -$signed(mag) : $signed(mag);
          r = clamp_word(sq);
        end
      end
      ACT_LT: r.cmp = a < b;
      ACT_GT: r.cmp = a > b;
      ACT_LE: r.cmp = a <= b;
      ACT_GE: r.cmp = a >= b;
      ACT_EQ: r.cmp = a == b;
      ACT_NE: r.cmp = a != b;
      ACT_MIN: r.value = (a < b) ? a : b;
      ACT_MAX: r.value = (b < a) ? a : b;
      ACT_INC: r.value = a + 1;
      ACT_DEC: r.value = a - 1;
      ACT_TO_INT: r.value = a >>> FRAC_BITS;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = expected_results.size();

  // Predict on input beats, compare on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t got, want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_results.push_back(alu_predict(action_i, operand_a_i, operand_b_i));
      if (out_valid_i && out_ready_i) begin
        got = {result_value_i, compare_true_i, divide_by_zero_i, saturated_i};
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("mismatch: value exp %h got %h, cmp %b/%b, dz %b/%b, sat %b/%b",
                       want.value, got.value, want.cmp, got.cmp, want.dz, got.dz,
                       want.sat, got.sat);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fpa_pkg::*;

  localparam int FracBits = FRAC_BITS_DEF;
  localparam int WordBits = WORD_BITS_DEF;
  localparam int Latency  = WordBits + FracBits + 3;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_off;

  fpa_in_if  #(.WordBits(WordBits)) in_ch ();
  fpa_out_if #(.WordBits(WordBits)) out_ch ();

  fixed_point_alu_unit #(.FRAC_BITS(FracBits), .WORD_BITS(WordBits)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  fpa_checker #(.FRAC_BITS(FracBits), .WORD_BITS(WordBits)) checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .action_i        (in_ch.action),
    .operand_a_i     (in_ch.operand_a),
    .operand_b_i     (in_ch.operand_b),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .result_value_i  (out_ch.result_value),
    .compare_true_i  (out_ch.compare_true),
    .divide_by_zero_i(out_ch.divide_by_zero),
    .saturated_i     (out_ch.saturated),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Limit the whole run.
  initial begin
    #40ms;
    $display("tb_top failed");
    $finish;
  end

  // Drive ready at the falling edge; honor a long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count out a long receiver stall while the sender keeps offering beats.
  task automatic stall_receiver(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(negedge clk_i);
    hold_off = 1'b0;
  endtask

  // Send one beat; valid stays high between back-to-back beats.
  task automatic send_beat(logic [ACTION_BITS-1:0] act, logic [WordBits-1:0] a,
                           logic [WordBits-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [WordBits-1:0] rand_operand();
    case ($urandom_range(5))
      0: return WordBits'({$urandom, $urandom});
      1: return WordBits'($signed($urandom_range(2047)) - 1024);
      2: return {1'b0, {(WordBits-1){1'b1}}} - WordBits'($urandom_range(3));
      3: return {1'b1, {(WordBits-1){1'b0}}} + WordBits'($urandom_range(3));
      default: return WordBits'($signed($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic run_random(int count);
    logic [ACTION_BITS-1:0] act;
    logic [WordBits-1:0] b;
    repeat (count) begin
      act = ACTION_BITS'($urandom_range(15));
      b = ($urandom_range(19) == 0) ? '0 : rand_operand();
      send_beat(act, rand_operand(), b);
    end
  endtask

  initial begin
    logic [WordBits-1:0] max_w, min_w;
    int wait_cycles;
    max_w = {1'b0, {(WordBits-1){1'b1}}};
    min_w = {1'b1, {(WordBits-1){1'b0}}};
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: each action, extremes, divide by zero, overflow, unused code.
    send_beat(ACT_ADD, max_w, 1);
    send_beat(ACT_SUB, min_w, 1);
    send_beat(ACT_MUL, max_w, max_w);
    send_beat(ACT_MUL, min_w, max_w);
    send_beat(ACT_MUL, 32'h180, 32'hFFFF_FF80);
    send_beat(ACT_DIV, 32'h100, '0);
    send_beat(ACT_DIV, max_w, 32'h1);
    send_beat(ACT_DIV, min_w, 32'h1);
    send_beat(ACT_DIV, min_w, '1);
    send_beat(ACT_DIV, 32'h100, 32'h300);
    send_beat(ACT_DIV, 32'hFFFF_FF00, 32'h200);
    send_beat(ACT_LT, min_w, max_w);
    send_beat(ACT_GT, min_w, max_w);
    send_beat(ACT_LE, 5, 5);
    send_beat(ACT_GE, '1, 0);
    send_beat(ACT_EQ, min_w, min_w);
    send_beat(ACT_NE, 3, 4);
    send_beat(ACT_MIN, min_w, max_w);
    send_beat(ACT_MAX, min_w, max_w);
    send_beat(ACT_INC, max_w, 0);
    send_beat(ACT_DEC, min_w, 0);
    send_beat(ACT_TO_INT, 32'hFFFF_FE80, 0);
    send_beat(ACT_TO_INT, max_w, 0);
    send_beat(4'd15, '1, '1);

    // Fill the pipeline against a stalled output.
    fork
      stall_receiver(200);
      run_random(100);
    join

    send_idle_pct = 20;
    recv_idle_pct = 75;
    run_random(430);
    send_idle_pct = 75;
    recv_idle_pct = 20;
    run_random(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(430);
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (2 * Latency) @(negedge clk_i);
    if (pending == 0 && fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
